// File: hw/rtl/mme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the integer matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int ACTION_W  = 2;
    localparam int ELEM_W    = 16;
    localparam int MUL_W     = 2 * ELEM_W;
    localparam int PROD_W    = 35;
    localparam int OUT_IDX_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } mme_state_t;

endpackage

// File: hw/rtl/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Integer matrix product C = A x B with one shared 16x16 multiplier and
// one read port per operand store, stepped by a small sequencer.
// Load transactions (A or B element) are accepted back to back while idle.
// A compute transaction walks every result element, stalling on the sink:
// inner reads through the shared multiply-accumulate, then a drain state.
// Results leave through an output register while the next element computes.
// Reset (synchronous, active low) clears control and pointers and sets dimensions to DIM_RESET.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]              cfg_wdata,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mme_pkg::ACTION_W-1:0]           s_action,
    input  logic signed [mme_pkg::ELEM_W-1:0]      s_element,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mme_pkg::PROD_W-1:0]      m_product,
    output logic [mme_pkg::OUT_IDX_W-1:0]          m_out_row,
    output logic [mme_pkg::OUT_IDX_W-1:0]          m_out_col,
    output logic                                   m_last
);

    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);

    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        begin
            if (v == '0) begin
                c = '0;
            end else if (v > CFG_W'(MAX_DIM)) begin
                c = CFG_W'(MAX_DIM - 1);
            end else begin
                c = v - CFG_W'(1);
            end
            return c[IDX_W-1:0];
        end
    endfunction

    logic [CFG_W-1:0]  rows_of_a_reg, inner_dim_reg, cols_of_b_reg;

    mme_state_t        state_reg, state_next;
    logic [PTR_W-1:0]  a_ptr_reg, a_ptr_next, b_ptr_reg, b_ptr_next;
    logic [IDX_W-1:0]  m_last_reg, m_last_next, kd_last_reg, kd_last_next;
    logic [IDX_W-1:0]  nc_last_reg, nc_last_next;
    logic [IDX_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next, a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic              m_valid_reg, m_valid_next;
    logic              acc_done_reg, acc_done_next;

    logic              s_accept, out_free, out_load, rd_en;
    logic              a_write, b_write;
    logic              elem_final;
    logic [ADDR_W-1:0] kd_step, nc_step;

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];
    logic signed [ELEM_W-1:0] a_rdata_reg, b_rdata_reg;
    logic                     rd_vld_reg, rd_first_reg, rd_last_reg;
    logic signed [MUL_W-1:0]  prod_reg;
    logic                     prod_vld_reg, prod_first_reg, prod_last_reg;
    logic signed [PROD_W-1:0] acc_reg;

    logic signed [PROD_W-1:0]  product_reg;
    logic [OUT_IDX_W-1:0]      out_row_reg, out_col_reg;
    logic                      last_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_of_a_reg <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_of_b_reg <= DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROWS_OF_A: rows_of_a_reg <= cfg_wdata;
                REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                REG_COLS_OF_B: cols_of_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign rd_en      = (state_reg == ST_RUN);
    assign a_write    = s_accept && (s_action == ACT_LOAD_A) && (a_ptr_reg < PTR_W'(DEPTH));
    assign b_write    = s_accept && (s_action == ACT_LOAD_B) && (b_ptr_reg < PTR_W'(DEPTH));
    assign elem_final = (i_reg == m_last_reg) && (j_reg == nc_last_reg);
    assign kd_step    = ADDR_W'(kd_last_reg) + ADDR_W'(1);
    assign nc_step    = ADDR_W'(nc_last_reg) + ADDR_W'(1);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            a_ptr_reg    <= '0;
            b_ptr_reg    <= '0;
            m_valid_reg  <= 1'b0;
            acc_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            a_ptr_reg    <= a_ptr_next;
            b_ptr_reg    <= b_ptr_next;
            m_valid_reg  <= m_valid_next;
            acc_done_reg <= acc_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_last_reg  <= m_last_next;
        kd_last_reg <= kd_last_next;
        nc_last_reg <= nc_last_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        a_base_reg  <= a_base_next;
        a_addr_reg  <= a_addr_next;
        b_addr_reg  <= b_addr_next;
    end

    always_comb begin
        state_next    = state_reg;
        a_ptr_next    = a_ptr_reg;
        b_ptr_next    = b_ptr_reg;
        m_last_next   = m_last_reg;
        kd_last_next  = kd_last_reg;
        nc_last_next  = nc_last_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        a_base_next   = a_base_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        out_load      = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        acc_done_next = acc_done_reg || (prod_vld_reg && prod_last_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_action)
                        ACT_LOAD_A: begin
                            if (a_write) begin
                                a_ptr_next = a_ptr_reg + PTR_W'(1);
                            end
                        end
                        ACT_LOAD_B: begin
                            if (b_write) begin
                                b_ptr_next = b_ptr_reg + PTR_W'(1);
                            end
                        end
                        ACT_COMPUTE: begin
                            a_ptr_next   = '0;
                            b_ptr_next   = '0;
                            m_last_next  = dim_last(rows_of_a_reg);
                            kd_last_next = dim_last(inner_dim_reg);
                            nc_last_next = dim_last(cols_of_b_reg);
                            i_next       = '0;
                            j_next       = '0;
                            k_next       = '0;
                            a_base_next  = '0;
                            a_addr_next  = '0;
                            b_addr_next  = '0;
                            state_next   = ST_RUN;
                        end
                        ACT_NOP: ;
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                if (k_reg == kd_last_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next      = k_reg + IDX_W'(1);
                    a_addr_next = a_addr_reg + ADDR_W'(1);
                    b_addr_next = b_addr_reg + nc_step;
                end
            end
            ST_DRAIN: begin
                if (acc_done_reg && out_free) begin
                    out_load      = 1'b1;
                    m_valid_next  = 1'b1;
                    acc_done_next = 1'b0;
                    k_next        = '0;
                    if (elem_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        if (j_reg == nc_last_reg) begin
                            j_next      = '0;
                            i_next      = i_reg + IDX_W'(1);
                            a_base_next = a_base_reg + kd_step;
                            a_addr_next = a_base_reg + kd_step;
                            b_addr_next = '0;
                        end else begin
                            j_next      = j_reg + IDX_W'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = ADDR_W'(j_reg) + ADDR_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operand stores
    always_ff @(posedge aclk) begin
        if (a_write) begin
            a_mem[a_ptr_reg[ADDR_W-1:0]] <= s_element;
        end
        if (b_write) begin
            b_mem[b_ptr_reg[ADDR_W-1:0]] <= s_element;
        end
        if (rd_en) begin
            a_rdata_reg <= a_mem[a_addr_reg];
            b_rdata_reg <= b_mem[b_addr_reg];
        end
    end

    // multiply-accumulate pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= rd_en;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg   <= (k_reg == '0);
        rd_last_reg    <= (k_reg == kd_last_reg);
        prod_first_reg <= rd_first_reg;
        prod_last_reg  <= rd_last_reg;
        prod_reg       <= a_rdata_reg * b_rdata_reg;
        if (prod_vld_reg) begin
            acc_reg <= (prod_first_reg ? '0 : acc_reg)
                       + {{(PROD_W - MUL_W){prod_reg[MUL_W-1]}}, prod_reg};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            product_reg <= acc_reg;
            out_row_reg <= OUT_IDX_W'(i_reg);
            out_col_reg <= OUT_IDX_W'(j_reg);
            last_reg    <= elem_final;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_product = product_reg;
    assign m_out_row = out_row_reg;
    assign m_out_col = out_col_reg;
    assign m_last    = last_reg;

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_done_reg |-> (state_reg == ST_DRAIN))
        else $error("finished sum outside drain");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (k_reg <= kd_last_reg))
        else $error("inner index past dimension");

    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> $past(rd_vld_reg))
        else $error("product without read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_action == ACT_COMPUTE)) |=> (a_ptr_reg == '0 && b_ptr_reg == '0))
        else $error("load pointers not cleared by compute transaction");

endmodule
